[rtl/fndp_pkg.sv]
// Shared constants for the fractional-N divider planner.
// Field widths, reset values and default parameter values; no dependencies.
package fndp_pkg;

   localparam int FREQ_W  = 23;
   localparam int PFD_W   = 17;
   localparam int INT_W   = 16;
   localparam int FRAC_W  = 12;
   localparam int EXP_W   = 3;

   // The divider remainder must hold twice the largest comparison frequency.
   localparam int REM_W   = PFD_W + 1;

   localparam int FRAC_MODULUS_DEF = 4000;
   localparam int MAX_DIV_EXP_DEF  = 7;

   localparam int VCO_FLOOR_KHZ = 3000000;
   localparam int INT_DIV_MAX   = 65535;

   localparam logic [PFD_W-1:0] PFD_RESET = PFD_W'(25000);

endpackage

[rtl/frac_n_divider_planner_top.sv]
// Fractional-N divider planner: frequency in kHz to exponent, integer and fraction.
// Uses fndp_pkg and fndp_div_chain.
// A new request is accepted only in the idle state, so no new item is taken until
// the result of the last one has been loaded into the output registers.
// Both divisions run through the same row of cells, the second entering part way.
// Synchronous reset clears the control state and sets pfd_ff to 25000 kHz.
module frac_n_divider_planner_top #(
   parameter int FRAC_MODULUS = fndp_pkg::FRAC_MODULUS_DEF,
   parameter int MAX_DIV_EXP  = fndp_pkg::MAX_DIV_EXP_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [fndp_pkg::PFD_W-1:0]  csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [fndp_pkg::FREQ_W-1:0] req_freq_khz,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [fndp_pkg::INT_W-1:0]  rsp_int_div,
   output logic [fndp_pkg::FRAC_W-1:0] rsp_frac_num,
   output logic [fndp_pkg::EXP_W-1:0]  rsp_div_exp,
   output logic                        rsp_out_of_range
);
   import fndp_pkg::*;

   localparam int VCO_W  = FREQ_W + MAX_DIV_EXP;
   localparam int NS_W   = VCO_W + 1;
   localparam int MUL_W  = PFD_W + FRAC_W + 1;
   localparam int DIV2_W = MUL_W + 1;
   localparam int ENTRY  = VCO_W - FRAC_W;

   localparam logic [FRAC_W:0]   TWO_M   = (FRAC_W + 1)'(2 * FRAC_MODULUS);
   localparam logic [FRAC_W-1:0] MODULUS = FRAC_W'(FRAC_MODULUS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXP   = 3'd1;
   localparam logic [2:0] ST_RUN1  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_LOAD2 = 3'd4;
   localparam logic [2:0] ST_RUN2  = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [PFD_W-1:0]  pfd_ff;
   logic [FREQ_W-1:0] freq_ff;
   logic [EXP_W-1:0]  exp_ff;
   logic              exp_flag_ff;
   logic [REM_W-1:0]  dvs_ff;
   logic [VCO_W-1:0]  n_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [MUL_W-1:0]  prod_ff;
   logic [FRAC_W-1:0] fr_ff;

   logic              rsp_valid_ff;
   logic [INT_W-1:0]  int_ff;
   logic [FRAC_W-1:0] frac_ff;
   logic [EXP_W-1:0]  dexp_ff;
   logic              oor_ff;

   logic [EXP_W-1:0]  exp_sel;
   logic              found;
   logic [VCO_W-1:0]  vco;
   logic [DIV2_W-1:0] dividend2;
   logic              tail_valid;
   logic [REM_W-1:0]  tail_rem;
   logic [VCO_W-1:0]  tail_quo;
   logic              carry;
   logic [NS_W-1:0]   n_sum;
   logic              sat;
   logic              load_out;
   logic              accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign load_out  = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      logic [VCO_W-1:0] shifted;
      exp_sel = EXP_W'(MAX_DIV_EXP);
      found   = 1'b0;
      for (int i = MAX_DIV_EXP; i >= 0; i--) begin
         shifted = VCO_W'(freq_ff) << i;
         if (shifted >= VCO_W'(VCO_FLOOR_KHZ)) begin
            exp_sel = EXP_W'(i);
            found   = 1'b1;
         end
      end
      vco = VCO_W'(freq_ff) << exp_sel;
   end

   assign dividend2 = DIV2_W'(prod_ff) + DIV2_W'(pfd_ff);

   fndp_div_chain #(
      .QUO_W(VCO_W),
      .ENTRY(ENTRY)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .dvs       (dvs_ff),
      .head_valid(state_ff == ST_EXP),
      .head_rem  ('0),
      .head_quo  (vco),
      .mid_valid (state_ff == ST_LOAD2),
      .mid_rem   (dividend2[FRAC_W +: REM_W]),
      .mid_quo   ({dividend2[FRAC_W-1:0], {ENTRY{1'b0}}}),
      .tail_valid(tail_valid),
      .tail_rem  (tail_rem),
      .tail_quo  (tail_quo)
   );

   always_comb begin
      carry = (fr_ff >= MODULUS);
      n_sum = NS_W'(n_ff) + NS_W'(carry);
      sat   = (pfd_ff == '0) || (n_sum > NS_W'(INT_DIV_MAX));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXP;
            end
         end
         ST_EXP: begin
            state_in = ST_RUN1;
         end
         ST_RUN1: begin
            if (tail_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_LOAD2;
         end
         ST_LOAD2: begin
            state_in = ST_RUN2;
         end
         ST_RUN2: begin
            if (tail_valid) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pfd_ff       <= PFD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            pfd_ff <= csr_wr_data;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         freq_ff <= req_freq_khz;
         dvs_ff  <= {1'b0, pfd_ff};
      end
      if (state_ff == ST_EXP) begin
         exp_ff      <= exp_sel;
         exp_flag_ff <= !found;
      end
      if (state_ff == ST_RUN1 && tail_valid) begin
         n_ff   <= tail_quo;
         rem_ff <= tail_rem;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= MUL_W'(rem_ff[PFD_W-1:0]) * MUL_W'(TWO_M);
         dvs_ff  <= {pfd_ff, 1'b0};
      end
      if (state_ff == ST_RUN2 && tail_valid) begin
         fr_ff <= tail_quo[FRAC_W-1:0];
      end
      if (load_out) begin
         int_ff  <= sat ? INT_W'(INT_DIV_MAX) : n_sum[INT_W-1:0];
         frac_ff <= (sat || carry) ? '0 : fr_ff;
         dexp_ff <= exp_ff;
         oor_ff  <= exp_flag_ff || sat;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_int_div      = int_ff;
   assign rsp_frac_num     = frac_ff;
   assign rsp_div_exp      = dexp_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

[rtl/fndp_div_cell.sv]
// One restoring division step with registered remainder and quotient.
// Uses fndp_pkg for the remainder width.
module fndp_div_cell #(
   parameter int QUO_W = 30
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [fndp_pkg::REM_W-1:0] in_rem,
   input  logic [QUO_W-1:0]           in_quo,
   input  logic [fndp_pkg::REM_W-1:0] dvs,
   output logic                       out_valid,
   output logic [fndp_pkg::REM_W-1:0] out_rem,
   output logic [QUO_W-1:0]           out_quo
);
   import fndp_pkg::*;

   logic             valid_ff;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [REM_W:0]   shifted;
   logic [REM_W:0]   diff;
   logic             ge;

   always_comb begin
      shifted = {in_rem, in_quo[QUO_W-1]};
      diff    = shifted - {1'b0, dvs};
      ge      = (shifted >= {1'b0, dvs});
      rem_in  = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
      quo_in  = {in_quo[QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;

endmodule

[rtl/fndp_div_chain.sv]
// Row of division cells, one quotient bit per cell, with a second entry point.
// Uses fndp_pkg and fndp_div_cell.
module fndp_div_chain #(
   parameter int QUO_W = 30,
   parameter int ENTRY = 18
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [fndp_pkg::REM_W-1:0] dvs,
   input  logic                       head_valid,
   input  logic [fndp_pkg::REM_W-1:0] head_rem,
   input  logic [QUO_W-1:0]           head_quo,
   input  logic                       mid_valid,
   input  logic [fndp_pkg::REM_W-1:0] mid_rem,
   input  logic [QUO_W-1:0]           mid_quo,
   output logic                       tail_valid,
   output logic [fndp_pkg::REM_W-1:0] tail_rem,
   output logic [QUO_W-1:0]           tail_quo
);
   import fndp_pkg::*;

   logic             link_valid [0:QUO_W];
   logic [REM_W-1:0] link_rem   [0:QUO_W];
   logic [QUO_W-1:0] link_quo   [0:QUO_W];

   assign link_valid[0] = head_valid;
   assign link_rem[0]   = head_rem;
   assign link_quo[0]   = head_quo;

   for (genvar k = 0; k < QUO_W; k++) begin : g_cell
      logic             c_valid;
      logic [REM_W-1:0] c_rem;
      logic [QUO_W-1:0] c_quo;

      if (k == ENTRY) begin : g_entry
         // A short division joins the row here, skipping the leading zero bits.
         assign c_valid = link_valid[k] | mid_valid;
         assign c_rem   = mid_valid ? mid_rem : link_rem[k];
         assign c_quo   = mid_valid ? mid_quo : link_quo[k];
      end else begin : g_plain
         assign c_valid = link_valid[k];
         assign c_rem   = link_rem[k];
         assign c_quo   = link_quo[k];
      end

      fndp_div_cell #(
         .QUO_W(QUO_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (c_valid),
         .in_rem   (c_rem),
         .in_quo   (c_quo),
         .dvs      (dvs),
         .out_valid(link_valid[k+1]),
         .out_rem  (link_rem[k+1]),
         .out_quo  (link_quo[k+1])
      );
   end

   assign tail_valid = link_valid[QUO_W];
   assign tail_rem   = link_rem[QUO_W];
   assign tail_quo   = link_quo[QUO_W];

endmodule

[bench/testbench.sv]
// Self-checking testbench for frac_n_divider_planner_top: sends frequency requests and
// comparison frequency writes, predicts every divider plan and checks results in order.
// Depends on fndp_pkg and the planner RTL; needs no other files.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fndp_pkg::*;

   localparam int SETTLE_CYCLES  = 50;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int IDLE_PCT       = 11;

   typedef enum logic [1:0] {ACT_FREQ, ACT_SET_PFD, ACT_DRAIN} action_kind_type;

   typedef struct packed {
      action_kind_type act;
      logic [31:0]     value;
   } action_type;

   typedef struct packed {
      logic [INT_W-1:0]  int_div;
      logic [FRAC_W-1:0] frac_num;
      logic [EXP_W-1:0]  div_exp;
      logic              out_of_range;
   } plan_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [PFD_W-1:0]  csr_wr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [FREQ_W-1:0] req_freq_khz = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [INT_W-1:0]  rsp_int_div;
   logic [FRAC_W-1:0] rsp_frac_num;
   logic [EXP_W-1:0]  rsp_div_exp;
   logic              rsp_out_of_range;

   action_type       pending_actions[$];
   plan_type         planned_results[$];
   logic [PFD_W-1:0] model_pfd = PFD_RESET;
   int               items_sent = 0;
   int               results_seen = 0;
   int               flagged_results = 0;
   int               pfd_writes = 0;
   int               mismatches = 0;
   int               settle = 0;
   int               hold_left = 0;
   bit               held_once = 1'b0;
   int               quiet = 0;

   frac_n_divider_planner_top dut (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .req_valid, .req_stall, .req_freq_khz,
      .rsp_valid, .rsp_stall, .rsp_int_div, .rsp_frac_num, .rsp_div_exp, .rsp_out_of_range
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic plan_type plan_dividers(logic [FREQ_W-1:0] freq, logic [PFD_W-1:0] pfd);
      plan_type    p;
      logic [63:0] vco, quo, rmd, fr;
      int          e;
      bit          flag;
      e = 0;
      flag = 1'b0;
      while (e <= MAX_DIV_EXP_DEF && (64'(freq) << e) < 64'(VCO_FLOOR_KHZ)) e++;
      if (e > MAX_DIV_EXP_DEF) begin
         e = MAX_DIV_EXP_DEF;
         flag = 1'b1;
      end
      vco = 64'(freq) << e;
      if (pfd == '0) begin
         quo = 64'(INT_DIV_MAX);
         fr = '0;
         flag = 1'b1;
      end else begin
         quo = vco / 64'(pfd);
         rmd = vco % 64'(pfd);
         fr = (2 * rmd * 64'(FRAC_MODULUS_DEF) + 64'(pfd)) / (2 * 64'(pfd));
         // Rounding up to the full modulus carries into the integer part.
         if (fr >= 64'(FRAC_MODULUS_DEF)) begin
            fr = '0;
            quo = quo + 1;
         end
         if (quo > 64'(INT_DIV_MAX)) begin
            quo = 64'(INT_DIV_MAX);
            fr = '0;
            flag = 1'b1;
         end
      end
      p.int_div = quo[INT_W-1:0];
      p.frac_num = fr[FRAC_W-1:0];
      p.div_exp = EXP_W'(e);
      p.out_of_range = flag;
      return p;
   endfunction

   function automatic logic [FREQ_W-1:0] pick_freq(logic [PFD_W-1:0] pfd);
      int unsigned mode, e, lo, hi;
      mode = $urandom_range(99);
      if (mode < 45) return FREQ_W'($urandom_range(6000000, 23500));
      if (mode < 60) return FREQ_W'($urandom_range((1 << FREQ_W) - 1));
      if (mode < 75) begin
         e = $urandom_range(MAX_DIV_EXP_DEF);
         return FREQ_W'(((VCO_FLOOR_KHZ + (1 << e) - 1) >> e) + $urandom_range(4) - 2);
      end
      if (mode < 90 && pfd != '0) begin
         // Just below a multiple of the comparison frequency, where rounding carries.
         lo = (VCO_FLOOR_KHZ + 3) / pfd + 1;
         hi = ((1 << FREQ_W) - 1) / pfd;
         return FREQ_W'(pfd * $urandom_range(hi, lo) - $urandom_range(3, 1));
      end
      return FREQ_W'($urandom_range(23499));
   endfunction

   function automatic bit steady_stretch(int count);
      return count >= 500 && count < 700;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH at result %0d, %s: got %0d, expected %0d", results_seen, what, got,
               want);
      mismatches++;
   endtask

   task automatic add_freq(int unsigned freq);
      pending_actions.push_back('{act: ACT_FREQ, value: freq});
   endtask

   task automatic add_pause();
      pending_actions.push_back('{act: ACT_DRAIN, value: '0});
   endtask

   task automatic set_pfd(int unsigned pfd);
      add_pause();
      pending_actions.push_back('{act: ACT_SET_PFD, value: pfd});
   endtask

   task automatic add_random_freqs(int count, logic [PFD_W-1:0] pfd);
      repeat (count) add_freq(32'(pick_freq(pfd)));
   endtask

   always @(posedge clock) begin
      logic              taken;
      logic              nxt_valid;
      logic              nxt_wr_en;
      logic [FREQ_W-1:0] nxt_freq;
      logic [PFD_W-1:0]  nxt_wr_data;
      action_type        head;
      taken = req_valid && !req_stall;
      nxt_valid = req_valid;
      nxt_freq = req_freq_khz;
      nxt_wr_en = 1'b0;
      nxt_wr_data = csr_wr_data;
      if (reset) begin
         nxt_valid = 1'b0;
         settle = 0;
      end else begin
         if (taken) begin
            planned_results.push_back(plan_dividers(req_freq_khz, model_pfd));
            items_sent++;
            nxt_valid = 1'b0;
         end
         if (!nxt_valid && pending_actions.size() > 0) begin
            head = pending_actions[0];
            case (head.act)
               ACT_FREQ: begin
                  if (steady_stretch(items_sent) || $urandom_range(99) >= IDLE_PCT) begin
                     nxt_valid = 1'b1;
                     nxt_freq = head.value[FREQ_W-1:0];
                     void'(pending_actions.pop_front());
                  end
               end
               ACT_DRAIN: begin
                  if (planned_results.size() == 0) settle++;
                  else settle = 0;
                  if (settle >= SETTLE_CYCLES) begin
                     settle = 0;
                     void'(pending_actions.pop_front());
                  end
               end
               ACT_SET_PFD: begin
                  nxt_wr_en = 1'b1;
                  nxt_wr_data = head.value[PFD_W-1:0];
                  model_pfd = head.value[PFD_W-1:0];
                  pfd_writes++;
                  void'(pending_actions.pop_front());
               end
               default: begin
                  void'(pending_actions.pop_front());
               end
            endcase
         end
      end
      req_valid <= nxt_valid;
      req_freq_khz <= nxt_freq;
      csr_wr_en <= nxt_wr_en;
      csr_wr_data <= nxt_wr_data;
   end

   always @(posedge clock) begin
      plan_type got;
      plan_type want;
      logic     nxt_stall;
      nxt_stall = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{int_div: rsp_int_div, frac_num: rsp_frac_num, div_exp: rsp_div_exp,
                    out_of_range: rsp_out_of_range};
            results_seen++;
            if (got.out_of_range === 1'b1) flagged_results++;
            if (planned_results.size() == 0) begin
               report_mismatch("item with nothing outstanding, int_div",
                               longint'(got.int_div), -1);
            end else begin
               want = planned_results.pop_front();
               if (got.int_div !== want.int_div)
                  report_mismatch("int_div", longint'(got.int_div), longint'(want.int_div));
               if (got.frac_num !== want.frac_num)
                  report_mismatch("frac_num", longint'(got.frac_num),
                                  longint'(want.frac_num));
               if (got.div_exp !== want.div_exp)
                  report_mismatch("div_exp", longint'(got.div_exp), longint'(want.div_exp));
               if (got.out_of_range !== want.out_of_range)
                  report_mismatch("out_of_range", longint'(got.out_of_range),
                                  longint'(want.out_of_range));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            nxt_stall = 1'b1;
         end else if (!held_once && results_seen >= 300 && req_valid) begin
            // Hold the result side long enough for the input side to back up.
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
            nxt_stall = 1'b1;
         end else begin
            nxt_stall = !steady_stretch(results_seen) && $urandom_range(99) < IDLE_PCT;
         end
      end
      rsp_stall <= nxt_stall;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, planned_results.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      logic [PFD_W-1:0] pfd;
      // Directed requests at the reset comparison frequency of 25000 kHz.
      add_freq(0);
      add_freq(1);
      add_freq((1 << FREQ_W) - 1);
      add_freq(23437);
      add_freq(23438);
      add_freq(23500);
      add_freq(1499999);
      add_freq(1500000);
      add_freq(2999999);
      add_freq(3000000);
      add_freq(6000000);
      add_freq(3024999);
      add_freq(3025000);
      add_freq(3012500);
      add_freq(4194304);
      add_freq(2796202);
      add_freq(5592405);
      add_random_freqs(120, PFD_RESET);

      set_pfd(0);
      add_freq(0);
      add_freq(3000000);
      add_freq((1 << FREQ_W) - 1);
      add_random_freqs(40, '0);

      set_pfd(10);
      add_random_freqs(80, PFD_W'(10));

      // A remainder of one over 64 lands exactly on a half and must round up.
      set_pfd(64);
      add_freq(3200001);
      add_freq(4194303);
      add_random_freqs(120, PFD_W'(64));
      add_pause();
      add_random_freqs(100, PFD_W'(64));

      set_pfd(105000);
      add_random_freqs(120, PFD_W'(105000));

      set_pfd((1 << PFD_W) - 1);
      add_random_freqs(120, PFD_W'((1 << PFD_W) - 1));

      repeat (3) begin
         pfd = PFD_W'($urandom_range(105000, 10));
         set_pfd(32'(pfd));
         add_random_freqs(120, pfd);
      end

      set_pfd(32'(PFD_RESET));
      add_random_freqs(40, PFD_RESET);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (pending_actions.size() != 0 || req_valid || planned_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d divider plans across %0d comparison frequency writes,", results_seen,
               pfd_writes);
      $display("including %0d flagged out of range and one long result-side hold.",
               flagged_results);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
